### src/dfmt_pkg.sv
// shared types and constants of the decimal field formatter
package dfmt_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned COL_W    = 7;
  localparam int unsigned PAGE_W   = 3;
  localparam int unsigned FONT_W   = 5;
  localparam int unsigned STEP_W   = 4;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned ROW_W    = 4;
  localparam int unsigned BCD_DIG_W = 4;
  localparam int unsigned CNT_W    = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
  localparam logic [ROW_W-1:0]  ROW_WRAP_INC = 4'd2;

  localparam int unsigned QUEUE_DEPTH = 2;

  // one classified formatting job handed from front to back
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [LEN_W-1:0]   len;
    logic [COL_W-1:0]   x0;
    logic [PAGE_W-1:0]  y0;
    logic [STEP_W-1:0]  step;
    logic               zpad;
  } dfmt_cmd_t;

endpackage

### src/dfmt_front.sv
// front end: accepts numbers, clamps the digit count, drops empty fields
module dfmt_front #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dfmt_pkg::VALUE_W-1:0]  value_i,
  input  logic [dfmt_pkg::LEN_W-1:0]    digit_count_i,
  input  logic [dfmt_pkg::COL_W-1:0]    start_column_i,
  input  logic [dfmt_pkg::PAGE_W-1:0]   page_row_i,
  input  logic [dfmt_pkg::FONT_W-1:0]   font_size_i,
  input  logic                          pad_with_zero_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output dfmt_pkg::dfmt_cmd_t           q_cmd_o
);
  import dfmt_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_DIGITS);

  logic [LEN_W-1:0] len_sat;

  always_comb begin
    len_sat = (digit_count_i > MAX_LEN) ? MAX_LEN : digit_count_i;
  end

  assign in_stall_o = q_full_i;
  // a zero-length field produces nothing, so it never enters the queue
  assign q_push_o   = in_valid_i && !q_full_i && (len_sat != '0);

  always_comb begin
    q_cmd_o.value = value_i;
    q_cmd_o.len   = len_sat;
    q_cmd_o.x0    = start_column_i;
    q_cmd_o.y0    = page_row_i;
    q_cmd_o.step  = font_size_i[FONT_W-1:1];
    q_cmd_o.zpad  = pad_with_zero_i;
  end

endmodule

### src/dfmt_queue.sv
// two-entry job queue between front and back
module dfmt_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dfmt_pkg::dfmt_cmd_t push_cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output dfmt_pkg::dfmt_cmd_t pop_cmd_o
);
  import dfmt_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_Q_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_Q_W-1:0] DEPTH_CNT = CNT_Q_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  dfmt_cmd_t          mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_Q_W-1:0] cnt_q;

  assign full_o    = (cnt_q == DEPTH_CNT);
  assign empty_o   = (cnt_q == '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_CNT)
    else $error("queue count out of range");

endmodule

### src/dfmt_back.sv
// back end: iterative binary to bcd conversion, then one character per cycle unless the output stalls
module dfmt_back #(
  parameter int unsigned MAX_DIGITS   = 10,
  parameter int unsigned LINE_COLUMNS = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  dfmt_pkg::dfmt_cmd_t           q_cmd_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dfmt_pkg::CHAR_W-1:0]   char_code_o,
  output logic [dfmt_pkg::COL_W-1:0]    column_o,
  output logic [dfmt_pkg::ROW_W-1:0]    row_o,
  output logic                          last_o
);
  import dfmt_pkg::*;

  localparam int unsigned BCD_W = MAX_DIGITS * BCD_DIG_W;
  localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [8:0]  LAST_COL = 9'(LINE_COLUMNS - 1);
  localparam logic [CNT_W-1:0] CONV_CYCLES = CNT_W'(VALUE_W);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} state_e;

  state_e               state_q;
  logic [VALUE_W-1:0]   value_q;
  logic [BCD_W-1:0]     bcd_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [IDX_W-1:0]     idx_q;
  logic [7:0]           col_q;
  logic [PAGE_W-1:0]    y0_q;
  logic [STEP_W-1:0]    step_q;
  logic                 zpad_q;
  logic                 shown_q;
  logic                 out_valid_q;
  logic [CHAR_W-1:0]    char_q;
  logic [COL_W-1:0]     column_q;
  logic [ROW_W-1:0]     row_q;
  logic                 last_q;

  logic [BCD_DIG_W-1:0] cur_digit;
  logic                 pad;
  logic                 is_last;
  logic [CHAR_W-1:0]    char_d;
  logic                 wrap;
  logic                 out_free;
  logic [BCD_W-1:0]     bcd_adj;

  // add 3 to every bcd digit of 5 or more before the shift
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b);
    logic [BCD_W-1:0] r;
    r = b;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (r[i*BCD_DIG_W +: BCD_DIG_W] >= 4'd5) begin
        r[i*BCD_DIG_W +: BCD_DIG_W] = r[i*BCD_DIG_W +: BCD_DIG_W] + 4'd3;
      end
    end
    return r;
  endfunction

  always_comb begin
    bcd_adj   = dabble(bcd_q);
    cur_digit = bcd_q[idx_q*BCD_DIG_W +: BCD_DIG_W];
    is_last   = (idx_q == '0);
    pad       = !shown_q && !is_last && (cur_digit == '0);
    if (pad) begin
      char_d = zpad_q ? CHAR_ZERO : CHAR_SPACE;
    end else begin
      char_d = CHAR_ZERO + CHAR_W'(cur_digit);
    end
    wrap     = ({1'b0, col_q} > LAST_COL);
    out_free = !out_valid_q || !out_stall_i;
  end

  assign q_pop_o     = (state_q == ST_IDLE) && !q_empty_i;
  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign column_o    = column_q;
  assign row_o       = row_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      value_q     <= '0;
      bcd_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      col_q       <= '0;
      y0_q        <= '0;
      step_q      <= '0;
      zpad_q      <= 1'b0;
      shown_q     <= 1'b0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      column_q    <= '0;
      row_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            value_q <= q_cmd_i.value;
            bcd_q   <= '0;
            cnt_q   <= CONV_CYCLES;
            idx_q   <= IDX_W'(q_cmd_i.len - 1'b1);
            col_q   <= {1'b0, q_cmd_i.x0};
            y0_q    <= q_cmd_i.y0;
            step_q  <= q_cmd_i.step;
            zpad_q  <= q_cmd_i.zpad;
            shown_q <= 1'b0;
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          // truncating the bcd register keeps only the low digits we need
          bcd_q   <= {bcd_adj[BCD_W-2:0], value_q[VALUE_W-1]};
          value_q <= value_q << 1;
          cnt_q   <= cnt_q - 1'b1;
          if (cnt_q == 6'd1) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            char_q      <= char_d;
            column_q    <= wrap ? '0 : col_q[COL_W-1:0];
            row_q       <= wrap ? ({1'b0, y0_q} + ROW_WRAP_INC) : {1'b0, y0_q};
            last_q      <= is_last;
            if (!pad) begin
              shown_q <= 1'b1;
            end
            col_q <= col_q + {4'd0, step_q};
            idx_q <= idx_q - 1'b1;
            if (is_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == ST_CONV))
    else $error("job popped without starting conversion");

  a_conv_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV && cnt_q == 6'd1) |=> (state_q == ST_EMIT))
    else $error("conversion did not finish after all bits");

  a_digit_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (cur_digit <= 4'd9))
    else $error("bcd digit out of range");

  a_last_ends_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && is_last) |=> (state_q == ST_IDLE && last_q))
    else $error("final character did not end the job");

endmodule

### src/decimal_field_formatter_unit.sv
// flow: an accepted number is queued, then run through the bit-serial 32-step
//   bcd conversion before its first character shows; one character follows per
//   cycle unless stalled; the back end takes one number at a time, and a
//   two-entry queue buffers jobs behind it
// reset: asynchronous active low, empties the queue and returns to idle
module decimal_field_formatter_unit #(
  parameter int unsigned MAX_DIGITS   = 10,
  parameter int unsigned LINE_COLUMNS = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dfmt_pkg::VALUE_W-1:0]  value_i,
  input  logic [dfmt_pkg::LEN_W-1:0]    digit_count_i,
  input  logic [dfmt_pkg::COL_W-1:0]    start_column_i,
  input  logic [dfmt_pkg::PAGE_W-1:0]   page_row_i,
  input  logic [dfmt_pkg::FONT_W-1:0]   font_size_i,
  input  logic                          pad_with_zero_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dfmt_pkg::CHAR_W-1:0]   char_code_o,
  output logic [dfmt_pkg::COL_W-1:0]    column_o,
  output logic [dfmt_pkg::ROW_W-1:0]    row_o,
  output logic                          last_o
);
  import dfmt_pkg::*;

  logic      q_push, q_full, q_pop, q_empty;
  dfmt_cmd_t push_cmd, pop_cmd;

  dfmt_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .value_i         (value_i),
    .digit_count_i   (digit_count_i),
    .start_column_i  (start_column_i),
    .page_row_i      (page_row_i),
    .font_size_i     (font_size_i),
    .pad_with_zero_i (pad_with_zero_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (push_cmd)
  );

  dfmt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_cmd_o  (pop_cmd)
  );

  dfmt_back #(
    .MAX_DIGITS   (MAX_DIGITS),
    .LINE_COLUMNS (LINE_COLUMNS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (pop_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .column_o    (column_o),
    .row_o       (row_o),
    .last_o      (last_o)
  );

endmodule
